>>> rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, operation codes and control types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int PRIO_BITS = 8;
  localparam int DATA_BITS = 32;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  // Fixed field widths of the result channel
  localparam int HEAD_BITS = 32;
  localparam int OCC_BITS  = 5;

  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REPORT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture the operands of an accepted item
    logic insert;   // place the captured entry in order
    logic remove;   // drop the head entry
    logic clear;    // empty the queue
  } dp_cmd_t;

  // Datapath to controller and top level
  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [CNT_BITS-1:0]  count;
    logic [DATA_BITS-1:0] head;
  } dp_sts_t;

endpackage

>>> rtl/core/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Operation sequencer: accepts an item, issues the update, then reports.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  in_func,
  input  dp_sts_t     sts,
  output dp_cmd_t     cmd,
  output logic        busy,
  output logic        report,
  output logic        overflow
);

  state_t state_r, state_nxt;
  op_t    func_r;
  logic   overflow_r, overflow_nxt;
  logic   accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      overflow_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= op_t'(in_func);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_EXEC;
      ST_EXEC:   state_nxt = ST_REPORT;
      ST_REPORT: state_nxt = start ? ST_EXEC : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    busy         = 1'b0;
    report       = 1'b0;
    overflow_nxt = overflow_r;
    cmd.load     = accept;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_EXEC: begin
        busy         = 1'b1;
        cmd.insert   = (func_r == OP_INSERT) && !sts.full;
        cmd.remove   = (func_r == OP_REMOVE) && !sts.empty;
        cmd.clear    = (func_r == OP_CLEAR);
        overflow_nxt = (func_r == OP_INSERT) && sts.full;
      end
      ST_REPORT: begin
        report = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign overflow = overflow_r;

endmodule

>>> rtl/core/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Row of sorted cells; every cell compares against the new entry in parallel.
// ----------------------------------------------------------------------------
module spq_datapath
  import spq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  input  logic [PRIO_BITS-1:0] in_priority_req,
  input  logic [DATA_BITS-1:0] in_payload,
  output dp_sts_t              sts
);

  logic [PRIO_BITS-1:0] prio_r [DEPTH];
  logic [DATA_BITS-1:0] data_r [DEPTH];
  logic [PRIO_BITS-1:0] prio_nxt [DEPTH];
  logic [DATA_BITS-1:0] data_nxt [DEPTH];
  logic [CNT_BITS-1:0]  count_r, count_nxt;
  logic [PRIO_BITS-1:0] op_prio_r;
  logic [DATA_BITS-1:0] op_data_r;
  logic [DEPTH-1:0]     ge;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_prio_r <= in_priority_req;
      op_data_r <= in_payload;
    end
  end

  // A held cell at or above the new priority stays; the list is sorted,
  // so these cells form a prefix.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CNT_BITS'(i) < count_r) && (prio_r[i] >= op_prio_r);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      prio_nxt[i] = prio_r[i];
      data_nxt[i] = data_r[i];
    end
    if (cmd.insert) begin
      if (!ge[0]) begin
        prio_nxt[0] = op_prio_r;
        data_nxt[0] = op_data_r;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (!ge[i]) begin
          if (ge[i-1]) begin
            prio_nxt[i] = op_prio_r;
            data_nxt[i] = op_data_r;
          end else begin
            prio_nxt[i] = prio_r[i-1];
            data_nxt[i] = data_r[i-1];
          end
        end
      end
    end else if (cmd.remove) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        prio_nxt[i] = prio_r[i+1];
        data_nxt[i] = data_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      prio_r[i] <= prio_nxt[i];
      data_r[i] <= data_nxt[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.insert) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (cmd.remove) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign sts.full  = (count_r == CNT_BITS'(DEPTH));
  assign sts.empty = (count_r == '0);
  assign sts.count = count_r;
  assign sts.head  = data_r[0];

endmodule

>>> rtl/core/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held in descending priority order, FIFO among equals.
// ----------------------------------------------------------------------------
// After the update state of an accepted item, its result strobe comes in the report state.
// Flow: busy is high only in the update cycle, and a new item may be taken
//   while the previous result is shown.
// All cells compare and shift at once in the update cycle.
// Reset (rst_n low, synchronous) empties the queue and returns to idle;
//   the cell contents are left as they are. Results cannot be stalled.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_func,
  input  logic [PRIO_BITS-1:0] in_priority_req,
  input  logic [DATA_BITS-1:0] in_payload,
  output logic                 out_valid,
  output logic [HEAD_BITS-1:0] out_head_payload,
  output logic                 out_is_empty,
  output logic [OCC_BITS-1:0]  out_occupancy,
  output logic                 out_overflow
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    report;
  logic    overflow;

  // Sequencer: take the item, issue one update, then show the result
  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_func  (in_func),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .report   (report),
    .overflow (overflow)
  );

  // Cell row: holds the sorted entries and the count
  spq_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_priority_req (in_priority_req),
    .in_payload      (in_payload),
    .sts             (sts)
  );

  // Drive the result straight from the cell row during the report cycle;
  // the cells hold until the next update, so the item is stable for its cycle.
  assign out_valid        = report;
  assign out_is_empty     = sts.empty;
  assign out_occupancy    = OCC_BITS'(sts.count);
  // Hide the head cell when nothing is held: its content is stale
  assign out_head_payload = sts.empty ? '0 : HEAD_BITS'(sts.head);
  assign out_overflow     = overflow;

endmodule

>>> rtl/core/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 out_valid,
  input  logic [HEAD_BITS-1:0] out_head_payload,
  input  logic                 out_is_empty,
  input  logic [OCC_BITS-1:0]  out_occupancy,
  input  logic                 out_overflow
);

  a_accept_yields_result: assert property (
    @(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid
  ) else $error("accepted item gave no result");

  a_empty_matches_count: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_occupancy == '0))
  ) else $error("empty flag disagrees with occupancy");

  a_empty_head_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_head_payload == '0)
  ) else $error("head data not zero on empty queue");

  a_overflow_only_full: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_occupancy == OCC_BITS'(DEPTH))
  ) else $error("overflow flagged on a queue that is not full");

  a_occupancy_bound: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= OCC_BITS'(DEPTH))
  ) else $error("occupancy beyond depth");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_head_payload (out_head_payload),
  .out_is_empty     (out_is_empty),
  .out_occupancy    (out_occupancy),
  .out_overflow     (out_overflow)
);

>>> verif/sorted_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test
// Self-checking bench for the sorted priority queue. A directed list of items
// walks the empty, full, equal-priority and clear cases. Random bursts follow
// that fill, drain and churn the queue. An in-bench model of the ordered store
// predicts each result; a strobed result is checked against it or a typed value.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;     // stray watch after the last result
  localparam int SHOW_LIMIT   = 10;

  // One result as the block reports it
  typedef struct packed {
    logic [HEAD_BITS-1:0] head;
    logic                 empty;
    logic [OCC_BITS-1:0]  occ;
    logic                 ovf;
  } queue_status_t;

  // One row of the directed list; typed rows carry their own expected result
  typedef struct {
    op_t                  op;
    logic [PRIO_BITS-1:0] prio;
    logic [DATA_BITS-1:0] data;
    bit                   typed;
    queue_status_t        status;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_func;
  logic [PRIO_BITS-1:0] in_priority_req;
  logic [DATA_BITS-1:0] in_payload;
  logic                 out_valid;
  logic [HEAD_BITS-1:0] out_head_payload;
  logic                 out_is_empty;
  logic [OCC_BITS-1:0]  out_occupancy;
  logic                 out_overflow;

  // Shadow of the ordered store, slot 0 holds the head
  logic [PRIO_BITS-1:0] held_prio [DEPTH];
  logic [DATA_BITS-1:0] held_data [DEPTH];
  int                   held_count;

  queue_status_t pending_status[$];
  stim_row_t     directed_rows[$];
  int            fail_count;
  int            result_count;
  int            cycle_count;

  sorted_priority_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_priority_req  (in_priority_req),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_head_payload (out_head_payload),
    .out_is_empty     (out_is_empty),
    .out_occupancy    (out_occupancy),
    .out_overflow     (out_overflow)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one operation to the shadow store and work out the result it gives
  task automatic next_queue_status(input op_t op, input logic [PRIO_BITS-1:0] prio,
                                   input logic [DATA_BITS-1:0] data,
                                   output queue_status_t st);
    int pos;
    int k;
    st.ovf = 1'b0;
    case (op)
      OP_INSERT: begin
        if (held_count >= DEPTH) begin
          // full: drop the entry and flag it
          st.ovf = 1'b1;
        end else begin
          // go behind every entry of equal or higher priority
          pos = 0;
          while (pos < held_count && held_prio[pos] >= prio) pos++;
          for (k = held_count; k > pos; k--) begin
            held_prio[k] = held_prio[k-1];
            held_data[k] = held_data[k-1];
          end
          held_prio[pos] = prio;
          held_data[pos] = data;
          held_count++;
        end
      end
      OP_REMOVE: begin
        if (held_count != 0) begin
          for (k = 0; k + 1 < held_count; k++) begin
            held_prio[k] = held_prio[k+1];
            held_data[k] = held_data[k+1];
          end
          held_count--;
        end
      end
      OP_CLEAR: held_count = 0;
      default: ;
    endcase
    st.head  = (held_count != 0) ? HEAD_BITS'(held_data[0]) : '0;
    st.empty = (held_count == 0);
    st.occ   = OCC_BITS'(held_count);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  // Present one item at the falling edge and hold it until it is taken
  task automatic send_item(input op_t op, input logic [PRIO_BITS-1:0] prio,
                           input logic [DATA_BITS-1:0] data, input bit typed,
                           input queue_status_t typed_status);
    queue_status_t st;
    @(negedge clk);
    start           = 1'b1;
    in_func         = op;
    in_priority_req = prio;
    in_payload      = data;
    @(posedge clk);
    while (busy) @(posedge clk);
    // taken at this edge: predict, and keep the typed value where there is one
    next_queue_status(op, prio, data, st);
    pending_status.push_back(typed ? typed_status : st);
  endtask

  // Idle the sender for a number of cycles, with noise on the idle fields
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start           = 1'b0;
      in_func         = 2'($urandom);
      in_priority_req = PRIO_BITS'($urandom);
      in_payload      = $urandom;
    end
  endtask

  task automatic add_row(input op_t op, input logic [PRIO_BITS-1:0] prio,
                         input logic [DATA_BITS-1:0] data);
    stim_row_t r;
    r.op     = op;
    r.prio   = prio;
    r.data   = data;
    r.typed  = 1'b0;
    r.status = '0;
    directed_rows.push_back(r);
  endtask

  task automatic add_typed_row(input op_t op, input logic [PRIO_BITS-1:0] prio,
                               input logic [DATA_BITS-1:0] data,
                               input logic [HEAD_BITS-1:0] head, input logic empty,
                               input logic [OCC_BITS-1:0] occ, input logic ovf);
    stim_row_t r;
    r.op     = op;
    r.prio   = prio;
    r.data   = data;
    r.typed  = 1'b1;
    r.status = '{head: head, empty: empty, occ: occ, ovf: ovf};
    directed_rows.push_back(r);
  endtask

  // Compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    queue_status_t want;
    queue_status_t got;
    if (rst_n && out_valid) begin
      got = '{head: out_head_payload, empty: out_is_empty, occ: out_occupancy,
              ovf: out_overflow};
      if (pending_status.size() == 0) begin
        note_failure($sformatf("result %0d with nothing pending: head %h empty %b occ %0d ovf %b",
                               result_count, got.head, got.empty, got.occ, got.ovf));
      end else begin
        want = pending_status.pop_front();
        if (got.head != want.head)
          note_failure($sformatf("result %0d head_payload: exp %h got %h",
                                 result_count, want.head, got.head));
        if (got.empty != want.empty)
          note_failure($sformatf("result %0d is_empty: exp %b got %b",
                                 result_count, want.empty, got.empty));
        if (got.occ != want.occ)
          note_failure($sformatf("result %0d occupancy: exp %0d got %0d",
                                 result_count, want.occ, got.occ));
        if (got.ovf != want.ovf)
          note_failure($sformatf("result %0d overflow: exp %b got %b",
                                 result_count, want.ovf, got.ovf));
      end
      result_count++;
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int sent;
    int burst;
    int mode;
    int pick;
    bit narrow;
    op_t op;
    logic [PRIO_BITS-1:0] prio;

    rst_n           = 1'b0;
    start           = 1'b0;
    in_func         = OP_NOP;
    in_priority_req = '0;
    in_payload      = '0;
    held_count      = 0;
    fail_count      = 0;
    result_count    = 0;

    // Empty queue: nop, remove and clear all report an empty head of zero
    add_typed_row(OP_NOP,    8'h00, 32'h0000_0000, 32'h0, 1'b1, 5'd0, 1'b0);
    add_typed_row(OP_REMOVE, 8'hFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 5'd0, 1'b0);
    add_typed_row(OP_CLEAR,  8'hFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 5'd0, 1'b0);
    // Extremes of priority and data; the second top priority queues behind the first
    add_typed_row(OP_INSERT, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 5'd1, 1'b0);
    add_typed_row(OP_INSERT, 8'hFF, 32'h0000_0000, 32'h0000_0000, 1'b0, 5'd2, 1'b0);
    add_typed_row(OP_INSERT, 8'hFF, 32'hA5A5_A5A5, 32'h0000_0000, 1'b0, 5'd3, 1'b0);
    add_typed_row(OP_REMOVE, 8'h00, 32'h0000_0000, 32'hA5A5_A5A5, 1'b0, 5'd2, 1'b0);
    // Fill to the brim with mixed and repeated priorities
    add_row(OP_INSERT, 8'h80, 32'h8000_0001);
    add_row(OP_INSERT, 8'h7F, 32'h7FFF_FFFE);
    add_row(OP_INSERT, 8'h01, 32'h0000_0001);
    add_row(OP_INSERT, 8'hFE, 32'hFEDC_BA98);
    add_row(OP_INSERT, 8'h80, 32'h8000_0002);
    add_row(OP_INSERT, 8'h00, 32'h0000_0000);
    add_row(OP_INSERT, 8'hFF, 32'h5A5A_5A5A);
    add_row(OP_INSERT, 8'h55, 32'h5555_5555);
    add_row(OP_INSERT, 8'hAA, 32'hAAAA_AAAA);
    add_row(OP_INSERT, 8'h10, 32'h0123_4567);
    add_row(OP_INSERT, 8'h80, 32'h8000_0003);
    add_row(OP_INSERT, 8'h01, 32'h0000_0002);
    add_row(OP_INSERT, 8'hC3, 32'hC3C3_C3C3);
    add_row(OP_INSERT, 8'h3C, 32'h3C3C_3C3C);
    // Full: the insert is dropped and flagged, the head stays put
    add_typed_row(OP_INSERT, 8'hFF, 32'h1234_5678, 32'hA5A5_A5A5, 1'b0, 5'd16, 1'b1);
    // Clear a full queue, then remove from the empty one
    add_typed_row(OP_CLEAR,  8'h00, 32'h0000_0000, 32'h0, 1'b1, 5'd0, 1'b0);
    add_typed_row(OP_REMOVE, 8'h00, 32'h0000_0000, 32'h0, 1'b1, 5'd0, 1'b0);

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed list, with the odd gap between items
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].prio, directed_rows[i].data,
                directed_rows[i].typed, directed_rows[i].status);
      if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 3));
    end

    // Random bursts: each burst leans towards filling, draining or churning,
    // and some use a narrow priority range so that ties are common
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst  = $urandom_range(1, 40);
      mode   = $urandom_range(0, 2);
      narrow = ($urandom_range(0, 2) == 0);
      for (int j = 0; j < burst && sent < RANDOM_ITEMS; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3)
          op = OP_CLEAR;
        else if (pick < 11)
          op = OP_NOP;
        else if (pick < (mode == 0 ? 80 : (mode == 1 ? 32 : 56)))
          op = OP_INSERT;
        else
          op = OP_REMOVE;
        prio = narrow ? PRIO_BITS'($urandom_range(0, 3)) : PRIO_BITS'($urandom);
        send_item(op, prio, $urandom, 1'b0, '0);
        sent++;
      end
      // leave some bursts back to back
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
    end
    hold_off(1);

    // Drain: wait for every outstanding result, then watch for strays
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
